// ----- rtl/ccv_pkg.sv -----
// Shared types and constants for the causal linear convolution block.
// No dependencies.
package ccv_pkg;

  localparam int IN_BITS  = 16;
  localparam int OUT_BITS = 40;
  localparam int POS_BITS = 8;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

endpackage

// ----- rtl/ccv_ram.sv -----
// Simple dual-port history memory: one write port, one registered read port.
// No dependencies.
module ccv_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ccv_mac.sv -----
// Shared multiply-accumulate unit; the sum saturates to the result width when the accumulator is wider.
// Depends on ccv_pkg.
module ccv_mac import ccv_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_W       = 41
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctrl_t                  ctrl,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic signed [SAMPLE_BITS-1:0] b,
  output logic [OUT_BITS-1:0]        sum,
  output logic                       busy
);

  localparam int PROD_W = 2 * SAMPLE_BITS;

  logic                     data_valid;
  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      data_valid <= ctrl.issue;
      prod_valid <= data_valid;
    end
    prod <= a * b;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign busy = data_valid || prod_valid;

  generate
    if (ACC_W > OUT_BITS) begin : g_sat
      localparam logic signed [ACC_W-1:0] OMAX =
        {{(ACC_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
      localparam logic signed [ACC_W-1:0] OMIN = ~OMAX;
      always_comb begin
        if (acc > OMAX) begin
          sum = OMAX[OUT_BITS-1:0];
        end else if (acc < OMIN) begin
          sum = OMIN[OUT_BITS-1:0];
        end else begin
          sum = acc[OUT_BITS-1:0];
        end
      end
    end else if (ACC_W == OUT_BITS) begin : g_same
      assign sum = acc;
    end else begin : g_ext
      assign sum = {{(OUT_BITS-ACC_W){acc[ACC_W-1]}}, acc};
    end
  endgenerate

endmodule

// ----- rtl/causal_linear_convolution.sv -----
// Top level: causal linear convolution over two stored sample histories.
// Depends on ccv_pkg, ccv_ram, ccv_mac.
//
//  channel  | dir | fields (tdata low bit up)                | tlast    | tuser
//  s_axis   | in  | sample_one[15:0], sample_two[31:16]      | last_pair| -
//  m_axis   | out | conv_value[39:0], position[47:40]        | last_out | overrun
//
// Position n is computed from n+1 reads through one shared MAC, then the
// product and accumulator registers, then the output register; a dropped
// (overrun) beat goes straight to the output register.
// s_tready is high only while idle; one result may wait in the output
// register while the next beat is accepted. Synchronous active-high reset.
module causal_linear_convolution import ccv_pkg::*; #(
  parameter int MAX_LENGTH  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample_one, sample_two
  input  logic        s_tlast,   // last_pair
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // conv_value, position
  output logic        m_tlast,   // last_out
  output logic        m_tuser    // overrun
);

  localparam int IDX_W = $clog2(MAX_LENGTH);
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int PW    = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
  localparam int ACC_W = 2 * SAMPLE_BITS + IDX_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

  state_t              state;
  logic [CNT_W-1:0]    fill_count;
  logic [IDX_W-1:0]    n;
  logic [IDX_W-1:0]    m;
  logic                last_q;
  logic                drop_q;
  logic [POS_BITS-1:0] pos_q;

  logic                   accept;
  logic                   drop_now;
  logic                   out_load;
  logic [PW-1:0]          pos_ext;
  logic [SAMPLE_BITS+IN_BITS-1:0] pad_one, pad_two;
  logic [SAMPLE_BITS-1:0] samp_one, samp_two;
  logic [SAMPLE_BITS-1:0] rd_one, rd_two;
  logic [OUT_BITS-1:0]    sum;
  logic                   mac_busy;
  mac_ctrl_t              mac_ctrl;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign drop_now = (fill_count == CNT_W'(MAX_LENGTH));
  assign pos_ext  = PW'(fill_count);
  assign out_load = (state == S_DRAIN) && !mac_busy && (!m_tvalid || m_tready);

  // bits above SAMPLE_BITS are ignored; wider samples see the field zero-extended
  assign pad_one  = {{SAMPLE_BITS{1'b0}}, s_tdata[15:0]};
  assign pad_two  = {{SAMPLE_BITS{1'b0}}, s_tdata[31:16]};
  assign samp_one = pad_one[SAMPLE_BITS-1:0];
  assign samp_two = pad_two[SAMPLE_BITS-1:0];

  assign mac_ctrl.clear = accept;
  assign mac_ctrl.issue = (state == S_RUN);

  ccv_ram #(.DEPTH(MAX_LENGTH), .WIDTH(SAMPLE_BITS)) u_hist_one (
    .clk   (clk),
    .we    (accept && !drop_now),
    .waddr (fill_count[IDX_W-1:0]),
    .wdata (samp_one),
    .raddr (m),
    .rdata (rd_one)
  );

  ccv_ram #(.DEPTH(MAX_LENGTH), .WIDTH(SAMPLE_BITS)) u_hist_two (
    .clk   (clk),
    .we    (accept && !drop_now),
    .waddr (fill_count[IDX_W-1:0]),
    .wdata (samp_two),
    .raddr (n - m),
    .rdata (rd_two)
  );

  ccv_mac #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_W(ACC_W)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a    (rd_one),
    .b    (rd_two),
    .sum  (sum),
    .busy (mac_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_q <= s_tlast;
            drop_q <= drop_now;
            pos_q  <= pos_ext[POS_BITS-1:0];
            n      <= fill_count[IDX_W-1:0];
            m      <= '0;
            if (s_tlast) begin
              fill_count <= '0;
            end else if (!drop_now) begin
              fill_count <= fill_count + 1'b1;
            end
            state <= drop_now ? S_DRAIN : S_RUN;
          end
        end
        S_RUN: begin
          m <= m + 1'b1;
          if (m == n) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (out_load) begin
            m_tdata  <= {pos_q, drop_q ? {OUT_BITS{1'b0}} : sum};
            m_tlast  <= last_q;
            m_tuser  <= drop_q;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ccv_check.sv -----
// Port-level checker for causal_linear_convolution, bound to the top level.
// Depends on causal_linear_convolution.
module ccv_check #(
  parameter int MAX_LENGTH = 256
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  localparam logic [7:0] DROP_POS = 8'(MAX_LENGTH);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted beat");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[39:0] == 40'd0 && m_tdata[47:40] == DROP_POS)
    else $error("overrun beat with nonzero value or wrong position");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind causal_linear_convolution ccv_check #(.MAX_LENGTH(MAX_LENGTH)) u_ccv_check (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for causal_linear_convolution: drives sample pairs over the
// input stream, predicts each truncated convolution value and checks the output stream.
// Depends on ccv_pkg and the causal_linear_convolution RTL.
module testbench;
  import ccv_pkg::*;

  localparam int MAX_LENGTH     = 256;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF       = 400;
  localparam int TAIL_CYCLES    = 300;
  localparam longint CONV_MAX   = (longint'(1) <<< (OUT_BITS - 1)) - 1;
  localparam longint CONV_MIN   = -CONV_MAX - 1;

  typedef struct {
    logic [IN_BITS-1:0] one;
    logic [IN_BITS-1:0] two;
    logic               last;
    logic               drain;
  } sample_pair_t;

  typedef struct {
    logic [OUT_BITS-1:0] value;
    logic [POS_BITS-1:0] pos;
    logic                last;
    logic                overrun;
  } conv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // sample_one, sample_two
  logic        s_tlast = 1'b0;  // last_pair
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;  // conv_value, position
  logic        m_tlast;  // last_out
  logic        m_tuser;  // overrun

  sample_pair_t pair_queue[$];
  conv_result_t expected_conv[$];

  logic signed [IN_BITS-1:0] hist_one [MAX_LENGTH];
  logic signed [IN_BITS-1:0] hist_two [MAX_LENGTH];
  int vec_fill = 0;

  int  errors = 0;
  int  results_seen = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  bit  hold_done = 1'b0;
  bit  sender_rush = 1'b0;
  bit  receiver_rush = 1'b0;
  bit  drain_next = 1'b0;

  causal_linear_convolution #(
    .MAX_LENGTH (MAX_LENGTH),
    .SAMPLE_BITS(IN_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Store the pair at the current position and sum first[m] * second[n-m] over 0..n; a full history drops the pair.
  task automatic convolve_pair(input logic [IN_BITS-1:0] one, input logic [IN_BITS-1:0] two,
                               input logic last);
    conv_result_t res;
    longint acc;
    int n;
    acc = 0;
    n = vec_fill;
    res.overrun = 1'b0;
    if (n >= MAX_LENGTH) begin
      res.overrun = 1'b1;
      n = MAX_LENGTH;
    end else begin
      hist_one[n] = one;
      hist_two[n] = two;
      for (int m = 0; m <= n; m++)
        acc += longint'(hist_one[m]) * longint'(hist_two[n - m]);
      if (acc > CONV_MAX) acc = CONV_MAX;
      if (acc < CONV_MIN) acc = CONV_MIN;
      vec_fill = n + 1;
    end
    if (last) vec_fill = 0;
    res.value = res.overrun ? '0 : acc[OUT_BITS-1:0];
    res.pos   = n[POS_BITS-1:0];
    res.last  = last;
    expected_conv.push_back(res);
  endtask

  function automatic logic [IN_BITS-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return IN_BITS'($urandom());
    endcase
  endfunction

  task automatic queue_vector(int len);
    sample_pair_t p;
    for (int i = 0; i < len; i++) begin
      p.one   = rand_sample();
      p.two   = rand_sample();
      p.last  = (i == len - 1);
      p.drain = drain_next && (i == 0);
      pair_queue.push_back(p);
    end
    drain_next = 1'b0;
  endtask

  task automatic queue_pair(logic [IN_BITS-1:0] one, logic [IN_BITS-1:0] two, logic last);
    sample_pair_t p;
    p.one   = one;
    p.two   = two;
    p.last  = last;
    p.drain = 1'b0;
    pair_queue.push_back(p);
  endtask

  // Sender: one item per slot, random gap after each, optional wait for a full drain.
  always @(posedge clk) begin
    sample_pair_t p;
    logic         valid_n;
    logic [31:0]  data_n;
    logic         last_n;
    valid_n = s_tvalid;
    data_n  = s_tdata;
    last_n  = s_tlast;
    if (rst) begin
      valid_n = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        convolve_pair(s_tdata[15:0], s_tdata[31:16], s_tlast);
        valid_n = 1'b0;
      end
      if (!valid_n) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pair_queue.size() > 0 &&
                     !(pair_queue[0].drain && expected_conv.size() > 0)) begin
          p = pair_queue.pop_front();
          valid_n = 1'b1;
          data_n  = {p.two, p.one};
          last_n  = p.last;
          if ($urandom_range(0, 29) == 0) sender_rush = !sender_rush;
          send_gap = sender_rush ? 0 : $urandom_range(0, 10);
        end
      end
    end
    s_tvalid <= valid_n;
    s_tdata  <= data_n;
    s_tlast  <= last_n;
  end

  // Receiver: checks each beat, random stall after each, one long hold-off.
  always @(posedge clk) begin
    conv_result_t want;
    logic         ready_n;
    if (rst) begin
      ready_n = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_conv.size() == 0) begin
          report_mismatch("unexpected beat, conv_value", $signed(m_tdata[39:0]), 0);
        end else begin
          want = expected_conv.pop_front();
          if (m_tdata[39:0] !== want.value)
            report_mismatch("conv_value", $signed(m_tdata[39:0]), $signed(want.value));
          if (m_tdata[47:40] !== want.pos)
            report_mismatch("position", m_tdata[47:40], want.pos);
          if (m_tlast !== want.last)
            report_mismatch("last_out", m_tlast, want.last);
          if (m_tuser !== want.overrun)
            report_mismatch("overrun", m_tuser, want.overrun);
        end
        if ($urandom_range(0, 29) == 0) receiver_rush = !receiver_rush;
        recv_gap = receiver_rush ? 0 : $urandom_range(0, 10);
        if (results_seen == 150 && !hold_done) begin
          hold_left = HOLD_OFF;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_n = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ready_n = 1'b0;
      end else begin
        ready_n = 1'b1;
      end
    end
    m_tready <= ready_n;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit long_done;
    bit over_done;
    long_done = 1'b0;
    over_done = 1'b0;

    // single-pair vectors at the corners
    queue_pair(16'h8000, 16'h8000, 1'b1);
    queue_pair(16'h7fff, 16'h8000, 1'b1);
    queue_pair(16'h7fff, 16'h7fff, 1'b1);
    // largest positive growth
    for (int i = 0; i < 4; i++) queue_pair(16'h8000, 16'h8000, i == 3);
    // largest negative growth
    for (int i = 0; i < 4; i++) queue_pair(16'h7fff, 16'h8000, i == 3);
    queue_pair(16'h5555, 16'haaaa, 1'b0);
    queue_pair(16'haaaa, 16'h5555, 1'b0);
    queue_pair(16'h0000, 16'h0000, 1'b0);
    queue_pair(16'h0001, 16'hffff, 1'b0);
    queue_pair(16'hffff, 16'h0001, 1'b1);

    drain_next = 1'b1;
    while (pair_queue.size() < 950) begin
      if (!long_done && pair_queue.size() > 300) begin
        // fills the history exactly, last on the final slot
        queue_vector(MAX_LENGTH);
        long_done = 1'b1;
      end else if (!over_done && pair_queue.size() > 600) begin
        // runs past the history; last lands on a dropped pair
        drain_next = 1'b1;
        queue_vector(MAX_LENGTH + $urandom_range(1, 5));
        over_done = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        queue_vector($urandom_range(25, 80));
      end else begin
        queue_vector($urandom_range(1, 16));
      end
    end

    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pair_queue.size() != 0 || s_tvalid || expected_conv.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && expected_conv.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
